@@ sv/bist_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bist_pkg;

  // request codes carried on mode_i
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_HAS    = 2'd3
  } mode_e;

  // request sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_GET,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ sv/bist_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                              wr_data_i,
  input  logic                                          rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ sv/bounded_id_set_table_unit.sv @@
// Bounded key set with compaction: a packed table of up to CAPACITY distinct keys.
// Request channel: in_valid_i / in_stall_o with mode_i, key_i, position_i.
// Result channel: out_valid_o / out_stall_i with status_o, present_o, read_key_o,
// occupancy_o; exactly one result beat per request beat, in request order.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_data_i writes the empty key;
// cfg_ready_o is always high; the user must make writes while no request is in
// flight, since the block does not enforce it. One request is worked on at a time.
// An in-range get reads its slot into the result register. Add, delete and has scan
// the table through the single read port of the slot memory, one entry per cycle,
// up to the match or to the count on a miss. Delete then moves every later entry
// down one place through the same port, one entry per cycle. A finished result sits
// in the output register; the next request may be taken while it waits, and the
// sequencer holds its own result until the output register is free, so a stalled
// receiver backs up into in_stall_o.
// Reset empties the table (count zero) and sets the empty key to all ones;
// the slot memory needs no clearing pass since only entries below the count
// are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_id_set_table_unit
  import bist_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [5:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        present_o,
  output logic [31:0] read_key_o,
  output logic [6:0]  occupancy_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int OW = (CW > 7) ? CW : 7;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [KW-1:0]   key_q, key_d;
  logic [KW-1:0]   empty_q;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rd_idx_q, rd_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]   cmp_idx_q, cmp_idx_d;
  logic            res_status_q, res_status_d;
  logic            res_present_q, res_present_d;
  logic [31:0]     res_key_q, res_key_d;
  logic            out_valid_q, out_valid_d;
  logic            out_status_q, out_present_q;
  logic [31:0]     out_key_q;
  logic [6:0]      out_occ_q;
  logic            out_load;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [KW-1:0]   ram_wdata, ram_rdata;

  logic            accept;
  logic [KW-1:0]   key_m;
  logic [PW-1:0]   pos_x, cnt_x;
  logic            found, issue;
  logic [OW-1:0]   occ_x;

  // slot memory
  bist_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign key_m       = key_i[KW-1:0];
  assign pos_x       = PW'(position_i);
  assign cnt_x       = PW'(count_q);

  // scan compare on the entry read last cycle
  assign found = cmp_vld_q && (ram_rdata == key_q);

  // sequencer: next state, memory access and result
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    key_d         = key_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    res_key_d     = res_key_q;
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_q - 1'b1;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_q[AW-1:0];
    issue         = 1'b0;
    out_load      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d        = mode_e'(mode_i);
          key_d         = key_m;
          rd_idx_d      = '0;
          res_status_d  = 1'b0;
          res_present_d = 1'b0;
          res_key_d     = '0;
          if (mode_e'(mode_i) == MODE_GET) begin
            if (pos_x < cnt_x) begin
              ram_re    = 1'b1;
              ram_raddr = pos_x[AW-1:0];
              state_d   = ST_GET;
            end else begin
              res_status_d = 1'b1;
              res_key_d    = 32'(empty_q);
              state_d      = ST_DONE;
            end
          end else if (key_m == empty_q) begin
            // empty key: add and delete fail, has answers absent
            res_status_d = (mode_e'(mode_i) != MODE_HAS);
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        issue = !found && (rd_idx_q < count_q);
        if (found) begin
          case (mode_q)
            MODE_HAS:    begin res_present_d = 1'b1; state_d = ST_DONE; end
            MODE_DELETE: state_d = ST_SHIFT;
            default:     state_d = ST_DONE;
          endcase
        end else if (issue) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!cmp_vld_q) begin
          // key not stored
          case (mode_q)
            MODE_ADD: begin
              if (count_q == CW'(CAPACITY)) begin
                res_status_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = key_q;
                count_d   = count_q + 1'b1;
              end
            end
            MODE_DELETE: res_status_d = 1'b1;
            default:     res_present_d = 1'b0;
          endcase
          state_d = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // read entry j, write it to j-1 in the next cycle; the freed top slot
        // is left as is since it lies above the count
        issue = (rd_idx_q < count_q);
        if (cmp_vld_q) begin
          ram_we = 1'b1;
        end
        if (issue) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!cmp_vld_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_GET: begin
        res_key_d = 32'(ram_rdata);
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);
  assign occ_x       = OW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      empty_q     <= '1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        empty_q <= cfg_data_i[KW-1:0];
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    key_q         <= key_d;
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    res_status_q  <= res_status_d;
    res_present_q <= res_present_d;
    res_key_q     <= res_key_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_present_q <= res_present_q;
      out_key_q     <= res_key_q;
      out_occ_q     <= occ_x[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign present_o   = out_present_q;
  assign read_key_o  = out_key_q;
  assign occupancy_o = out_occ_q;

endmodule

`default_nettype wire

@@ test/tb_bounded_id_set_table_unit.sv @@
`timescale 1ns / 1ps

module tb_bounded_id_set_table_unit;
  import bist_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 200;
  localparam int KEY_POOL_SIZE  = 72;
  localparam int MAX_PRINTS     = 100;

  typedef struct packed {
    logic        status;
    logic        present;
    logic [31:0] read_key;
    logic [6:0]  occupancy;
  } table_result_t;

  typedef enum int {
    PH_GROW,
    PH_CHURN,
    PH_SHRINK
  } phase_e;

  // dut connections
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        req_valid    = 1'b0;
  logic        req_stall;
  logic [1:0]  req_mode     = MODE_ADD;
  logic [31:0] req_key      = '0;
  logic [5:0]  req_position = '0;
  logic        rsp_valid;
  logic        rsp_stall    = 1'b0;
  logic        rsp_status;
  logic        rsp_present;
  logic [31:0] rsp_read_key;
  logic [6:0]  rsp_occupancy;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data     = '0;

  // mirror of the key table and the empty key
  logic [31:0] tbl_keys [CAPACITY];
  int          tbl_count;
  logic [31:0] cur_empty_key;

  table_result_t pending_results [$];
  logic [31:0]   key_pool [KEY_POOL_SIZE];
  int            walk_idx     = 0;
  int            burst_left   = 0;
  int            error_count  = 0;
  int            checked      = 0;
  int            full_hits    = 0;
  int            cfg_writes   = 0;
  int            mode_count [4] = '{0, 0, 0, 0};
  int            idle_cycles  = 0;

  // receiver stall pattern state
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_style = 0;
  int   style_left  = 0;
  int   cycle_cnt   = 0;

  bounded_id_set_table_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .mode_i      (req_mode),
    .key_i       (req_key),
    .position_i  (req_position),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .status_o    (rsp_status),
    .present_o   (rsp_present),
    .read_key_o  (rsp_read_key),
    .occupancy_o (rsp_occupancy),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted outcome of one request, updating the mirror table
  function automatic table_result_t predict_table_op(mode_e m, logic [31:0] k,
                                                     logic [5:0] p);
    table_result_t r;
    int at;
    r = '0;
    at = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (at < 0 && tbl_keys[i] == k) at = i;
    end
    case (m)
      MODE_ADD: begin
        if (k == cur_empty_key) begin
          r.status = 1'b1;
        end else if (at < 0) begin
          if (tbl_count >= CAPACITY) begin
            r.status = 1'b1;
            full_hits++;
          end else begin
            tbl_keys[tbl_count] = k;
            tbl_count++;
          end
        end
      end
      MODE_DELETE: begin
        if (k == cur_empty_key || at < 0) begin
          r.status = 1'b1;
        end else begin
          // compaction: later entries move down one place
          for (int i = at; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i + 1];
          tbl_count--;
          tbl_keys[tbl_count] = cur_empty_key;
        end
      end
      MODE_GET: begin
        if (int'(p) < tbl_count) begin
          r.read_key = tbl_keys[p];
        end else begin
          r.read_key = cur_empty_key;
          r.status   = 1'b1;
        end
      end
      default: begin
        r.present = (k != cur_empty_key) && (at >= 0);
      end
    endcase
    r.occupancy = 7'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("mismatch on %s at beat %0d: got %h, want %h", what, checked, got, want);
    error_count++;
  endtask

  // one request beat, with burst gaps on the sender side
  task automatic send_request(mode_e m, logic [31:0] k, logic [5:0] p);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
    end
    burst_left--;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    req_mode     <= m;
    req_key      <= k;
    req_position <= p;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(predict_table_op(m, k, p));
    mode_count[int'(m)]++;
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_empty_key(logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cur_empty_key = value;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // key choice: mostly pool or stored keys, some empty key and raw noise
  function automatic logic [31:0] pick_key(mode_e m, phase_e ph);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return cur_empty_key;
    if (roll < 18) return $urandom();
    if (m == MODE_ADD && ph == PH_GROW && roll < 85) begin
      walk_idx = (walk_idx + 1) % KEY_POOL_SIZE;
      return key_pool[walk_idx];
    end
    if (m != MODE_ADD && tbl_count != 0 && roll < 60)
      return tbl_keys[$urandom_range(tbl_count - 1)];
    return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
  endfunction

  task automatic run_phase(phase_e ph, int n);
    int roll;
    int add_w;
    int del_w;
    int get_w;
    mode_e m;
    logic [31:0] k;
    logic [5:0] p;
    case (ph)
      PH_GROW:  begin add_w = 85; del_w = 5;  get_w = 5;  end
      PH_CHURN: begin add_w = 30; del_w = 30; get_w = 20; end
      default:  begin add_w = 10; del_w = 60; get_w = 15; end
    endcase
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < add_w) m = MODE_ADD;
      else if (roll < add_w + del_w) m = MODE_DELETE;
      else if (roll < add_w + del_w + get_w) m = MODE_GET;
      else m = MODE_HAS;
      k = pick_key(m, ph);
      if (tbl_count != 0 && $urandom_range(1) == 1) p = 6'($urandom_range(tbl_count - 1));
      else p = 6'($urandom_range(63));
      send_request(m, k, p);
    end
  endtask

  // requests on a table that holds nothing
  task automatic test_empty_table();
    send_request(MODE_DELETE, 32'h0000_0001, 6'd0);
    send_request(MODE_GET, 32'h0, 6'd0);
    send_request(MODE_GET, 32'h0, 6'd63);
    send_request(MODE_HAS, 32'h0000_0001, 6'd0);
    send_request(MODE_ADD, 32'hFFFF_FFFF, 6'd0);
  endtask

  // adds, duplicate add, membership and reads by index
  task automatic test_add_and_lookup();
    send_request(MODE_ADD, 32'h0000_0000, 6'd0);
    send_request(MODE_ADD, 32'h7FFF_FFFF, 6'd0);
    send_request(MODE_ADD, 32'hFFFF_FFFE, 6'd0);
    send_request(MODE_ADD, 32'h0000_0000, 6'd0);
    send_request(MODE_HAS, 32'h0000_0000, 6'd0);
    send_request(MODE_HAS, 32'hFFFF_FFFF, 6'd0);
    send_request(MODE_HAS, 32'h1234_5678, 6'd0);
    send_request(MODE_GET, 32'h0, 6'd2);
    send_request(MODE_GET, 32'h0, 6'd3);
  endtask

  // failed deletes, then removal from the middle and the ends
  task automatic test_delete_compaction();
    send_request(MODE_DELETE, 32'h1234_5678, 6'd0);
    send_request(MODE_DELETE, 32'hFFFF_FFFF, 6'd0);
    send_request(MODE_DELETE, 32'h7FFF_FFFF, 6'd0);
    send_request(MODE_GET, 32'h0, 6'd1);
    send_request(MODE_GET, 32'h0, 6'd2);
    send_request(MODE_DELETE, 32'h0000_0000, 6'd0);
    send_request(MODE_DELETE, 32'hFFFF_FFFE, 6'd0);
  endtask

  // empty key moved, including onto a key that is already stored
  task automatic test_empty_key_change();
    write_empty_key(32'h0000_0000);
    send_request(MODE_ADD, 32'h0000_0000, 6'd0);
    send_request(MODE_ADD, 32'hFFFF_FFFF, 6'd0);
    send_request(MODE_ADD, 32'hA5A5_A5A5, 6'd0);
    write_empty_key(32'hA5A5_A5A5);
    send_request(MODE_GET, 32'h0, 6'd1);
    send_request(MODE_HAS, 32'hA5A5_A5A5, 6'd0);
    send_request(MODE_DELETE, 32'hA5A5_A5A5, 6'd0);
    send_request(MODE_ADD, 32'hA5A5_A5A5, 6'd0);
    write_empty_key(32'h0000_0000);
    send_request(MODE_DELETE, 32'hFFFF_FFFF, 6'd0);
    send_request(MODE_DELETE, 32'hA5A5_A5A5, 6'd0);
  endtask

  // grow, churn and shrink phases under several empty keys
  task automatic test_random_traffic();
    logic [31:0] settings [4];
    foreach (key_pool[i]) key_pool[i] = $urandom();
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = 32'h0000_0000;
    settings[2] = $urandom();
    settings[3] = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    foreach (settings[s]) begin
      write_empty_key(settings[s]);
      run_phase(PH_GROW, 110);
      run_phase(PH_CHURN, 80);
      run_phase(PH_SHRINK, 70);
    end
  endtask

  // receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    write_empty_key(32'hFFFF_FFFF);
    hold_tog <= ~hold_tog;
    run_phase(PH_GROW, 20);
    run_phase(PH_CHURN, 20);
  endtask

  // receiver stall pattern, changing style every so often
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(3);
        style_left  <= $urandom_range(120, 20);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(3) == 0);
        2:       rsp_stall <= ($urandom_range(3) != 0);
        default: rsp_stall <= ((cycle_cnt % 7) < 3);
      endcase
    end
  end

  // result beat checker
  always @(posedge clk) begin : check_beat
    table_result_t want;
    if (rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", rsp_read_key, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_status !== want.status)
          report_mismatch("status", 32'(rsp_status), 32'(want.status));
        if (rsp_present !== want.present)
          report_mismatch("present", 32'(rsp_present), 32'(want.present));
        if (rsp_read_key !== want.read_key)
          report_mismatch("read_key", rsp_read_key, want.read_key);
        if (rsp_occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(rsp_occupancy), 32'(want.occupancy));
      end
      checked++;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("tb_bounded_id_set_table_unit: errors");
      $finish;
    end
  end

  initial begin
    cur_empty_key = 32'hFFFF_FFFF;
    tbl_count     = 0;
    foreach (tbl_keys[i]) tbl_keys[i] = 32'hFFFF_FFFF;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_and_lookup();
    test_delete_compaction();
    test_empty_key_change();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 32'h0);

    $display("covered %0d requests: %0d add, %0d delete, %0d get, %0d has",
             mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d empty key writes, %0d result beats checked, %0d adds refused on full",
             cfg_writes, checked, full_hits);
    if (error_count == 0) begin
      $display("tb_bounded_id_set_table_unit: clean");
    end else begin
      $display("tb_bounded_id_set_table_unit: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bist_pkg.sv
sv/bist_ram.sv
sv/bounded_id_set_table_unit.sv
test/tb_bounded_id_set_table_unit.sv
